### rtl/core/assert_macros.svh
// assertion macros for the deframer rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property, checked out of reset
`define MPHD_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen out of reset
`define MPHD_NEVER(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### rtl/core/mphd_pkg.sv
// types, constants and helpers for the management packet deframer
// used by mphd_decode and mgmt_packet_hop_deframer_top
package mphd_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned HOP_W   = 10;
    localparam int unsigned PAD_W   = 3;
    localparam int unsigned OPS_W   = 8;

    localparam logic REC_HEADER = 1'b0;
    localparam logic REC_OP     = 1'b1;

    typedef enum logic [3:0] {
        PH_HDR     = 4'b0001,
        PH_OP      = 4'b0010,
        PH_PAD_OP  = 4'b0100,
        PH_PAD_HDR = 4'b1000
    } phase_t;

    typedef struct packed {
        phase_t           phase;
        logic [PAD_W-1:0] pad_size;
        logic [PAD_W-1:0] pad_left;
        logic [HOP_W-1:0] hops_total;
        logic [HOP_W-1:0] hop_idx;
    } mphd_state_t;

    typedef struct packed {
        logic             record_kind;
        logic [15:0]      src_endpoint;
        logic [2:0]       width_code;
        logic [15:0]      proto_version;
        logic [HOP_W-1:0] hop_count;
        logic [HOP_W-1:0] hop_number;
        logic [7:0]       op_kind;
        logic [47:0]      op_data;
        logic [OPS_W-1:0] ops_left;
        logic             last;
        logic             error;
    } rec_t;

    function automatic logic [WORD_W-1:0] byte_reverse(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            r[8*i +: 8] = v[8*(7-i) +: 8];
        end
        return r;
    endfunction

    // codes above 3 are undefined and saturate
    function automatic logic [PAD_W-1:0] pad_from_code(input logic [2:0] code);
        logic [PAD_W-1:0] p;
        case (code)
            3'd0:    p = 3'd0;
            3'd1:    p = 3'd1;
            3'd2:    p = 3'd3;
            default: p = 3'd7;
        endcase
        return p;
    endfunction

endpackage

### rtl/core/mphd_ifs.sv
// valid/ready channel interfaces for packet words and decoded records
// no dependencies
interface mphd_word_if;
    logic        valid;
    logic        ready;
    logic [63:0] word;
    logic        first;

    modport source (output valid, output word, output first, input ready);
    modport sink   (input valid, input word, input first, output ready);
endinterface

interface mphd_rec_if;
    logic        valid;
    logic        ready;
    logic        record_kind;
    logic [15:0] src_endpoint;
    logic [2:0]  width_code;
    logic [15:0] proto_version;
    logic [9:0]  hop_count;
    logic [9:0]  hop_number;
    logic [7:0]  op_kind;
    logic [47:0] op_data;
    logic [7:0]  ops_left;
    logic        last;
    logic        error;

    modport source (
        output valid, output record_kind, output src_endpoint, output width_code,
        output proto_version, output hop_count, output hop_number, output op_kind,
        output op_data, output ops_left, output last, output error, input ready
    );
    modport sink (
        input valid, input record_kind, input src_endpoint, input width_code,
        input proto_version, input hop_count, input hop_number, input op_kind,
        input op_data, input ops_left, input last, input error, output ready
    );
endinterface

### rtl/core/mphd_decode.sv
// single word decode: record fields and next parser state
// depends on mphd_pkg
module mphd_decode (
    input  logic [63:0]           word,
    input  logic                  first,
    input  logic                  swap,
    input  mphd_pkg::mphd_state_t cur,
    output mphd_pkg::mphd_state_t nxt,
    output logic                  emit,
    output mphd_pkg::rec_t        rec
);
    import mphd_pkg::*;

    logic [WORD_W-1:0] w;
    logic [2:0]        code;
    logic [PAD_W-1:0]  pad_new;
    logic [HOP_W-1:0]  hops_new;
    logic [OPS_W-1:0]  ops;
    logic [HOP_W-1:0]  hop_inc;
    logic              done;
    logic [PAD_W-1:0]  pad_dec;

    always_comb
    begin
        w        = swap ? byte_reverse(word) : word;
        code     = w[47:45];
        pad_new  = pad_from_code(code);
        hops_new = w[25:16];
        ops      = w[7:0];
        hop_inc  = cur.hop_idx + HOP_W'(ops == '0);
        pad_dec  = (cur.pad_left != '0) ? cur.pad_left - PAD_W'(1) : cur.pad_left;
        done     = 1'b0;
        nxt      = cur;
        emit     = 1'b0;
        rec      = '0;

        if (first)
        begin
            done              = (hops_new == '0);
            emit              = 1'b1;
            rec.record_kind   = REC_HEADER;
            rec.src_endpoint  = w[15:0];
            rec.width_code    = code;
            rec.proto_version = w[63:48];
            rec.hop_count     = hops_new;
            rec.last          = done;
            rec.error         = (cur.phase != PH_HDR);
            nxt.hops_total    = hops_new;
            nxt.hop_idx       = '0;
            nxt.pad_size      = pad_new;
            nxt.pad_left      = pad_new;
            if (pad_new != '0)
                nxt.phase = done ? PH_PAD_HDR : PH_PAD_OP;
            else
                nxt.phase = done ? PH_HDR : PH_OP;
        end
        else
        begin
            case (cur.phase)
                PH_OP:
                begin
                    done            = (ops == '0) && (hop_inc == cur.hops_total);
                    emit            = 1'b1;
                    rec.record_kind = REC_OP;
                    rec.hop_number  = cur.hop_idx;
                    rec.op_kind     = w[15:8];
                    rec.op_data     = w[63:16];
                    rec.ops_left    = ops;
                    rec.last        = done;
                    nxt.hop_idx     = hop_inc;
                    nxt.pad_left    = cur.pad_size;
                    if (cur.pad_size != '0)
                        nxt.phase = done ? PH_PAD_HDR : PH_PAD_OP;
                    else
                        nxt.phase = done ? PH_HDR : PH_OP;
                end
                PH_PAD_OP, PH_PAD_HDR:
                begin
                    nxt.pad_left = pad_dec;
                    if (pad_dec == '0)
                        nxt.phase = (cur.phase == PH_PAD_OP) ? PH_OP : PH_HDR;
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end
    end

endmodule

### rtl/core/mgmt_packet_hop_deframer_top.sv
// management packet deframer top: parser state, swap register, record register
// depends on mphd_pkg, mphd_ifs, mphd_decode and assert_macros.svh
//
// usage
// - pkt carries one 64-bit packet word per beat, first marks the header word
// - rec carries one decoded record per beat: a header record per header word,
//   an op record per op word; padding words and stray words give no beat
// - cfg_wr_en/cfg_wr_data set swap_bytes; write it only while the block is idle
// - a record is registered and appears on rec in the cycle after its word is taken
// - throughput: one word per cycle while rec does not stall, set by the single record register
// - pkt.ready is high while the record register is empty or being drained
// - when rec stalls, the record is held and pkt.ready drops in the same cycle
// - reset clears the parser to expect a header, swap_bytes to 0 and rec.valid
`include "assert_macros.svh"

module mgmt_packet_hop_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    mphd_word_if.sink   pkt,
    mphd_rec_if.source  rec
);
    import mphd_pkg::*;

    mphd_state_t state_reg;
    mphd_state_t state_next;
    logic        swap_bytes_reg;
    logic        rec_valid_reg;
    rec_t        rec_reg;
    rec_t        rec_next;
    logic        emit;
    logic        accept;

    assign pkt.ready = !rec_valid_reg || rec.ready;
    assign accept    = pkt.valid && pkt.ready;

    mphd_decode u_decode (
        .word  (pkt.word),
        .first (pkt.first),
        .swap  (swap_bytes_reg),
        .cur   (state_reg),
        .nxt   (state_next),
        .emit  (emit),
        .rec   (rec_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_bytes_reg       <= 1'b0;
            state_reg.phase      <= PH_HDR;
            state_reg.pad_size   <= '0;
            state_reg.pad_left   <= '0;
            state_reg.hops_total <= '0;
            state_reg.hop_idx    <= '0;
            rec_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                swap_bytes_reg <= cfg_wr_data;
            if (accept)
                state_reg <= state_next;
            if (accept && emit)
                rec_valid_reg <= 1'b1;
            else if (rec.ready)
                rec_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
            rec_reg <= rec_next;
    end

    assign rec.valid         = rec_valid_reg;
    assign rec.record_kind   = rec_reg.record_kind;
    assign rec.src_endpoint  = rec_reg.src_endpoint;
    assign rec.width_code    = rec_reg.width_code;
    assign rec.proto_version = rec_reg.proto_version;
    assign rec.hop_count     = rec_reg.hop_count;
    assign rec.hop_number    = rec_reg.hop_number;
    assign rec.op_kind       = rec_reg.op_kind;
    assign rec.op_data       = rec_reg.op_data;
    assign rec.ops_left      = rec_reg.ops_left;
    assign rec.last          = rec_reg.last;
    assign rec.error         = rec_reg.error;

    // header with no hops closes the packet
    `MPHD_ASSERT(a_empty_hdr_last, clk, rst_n,
        (rec_valid_reg && rec_reg.record_kind == REC_HEADER && rec_reg.hop_count == '0)
        |-> rec_reg.last, "header without hops not marked last")
    `MPHD_NEVER(a_op_no_error, clk, rst_n,
        rec_valid_reg && rec_reg.record_kind == REC_OP && rec_reg.error,
        "op record carries error")
    `MPHD_NEVER(a_pad_phase, clk, rst_n,
        state_reg.pad_left != '0 && state_reg.phase != PH_PAD_OP
        && state_reg.phase != PH_PAD_HDR, "padding left outside a padding phase")
    `MPHD_NEVER(a_hop_bound, clk, rst_n,
        state_reg.hop_idx > state_reg.hops_total, "hop index past hop count")

endmodule
